FILE: rtl/stable_priority_queue_core_macros.svh
// assertion helpers for the checker file
`ifndef STABLE_PRIORITY_QUEUE_CORE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("spq assertion failed");

// next-cycle implication, disabled while reset is low
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spq assertion failed");

`endif

FILE: rtl/spq_pkg.sv
package spq_pkg;

	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam int STATUS_W = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		MODE_PUSH = 1'b0,
		MODE_POP  = 1'b1
	} mode_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic push;
		logic pop;
	} spq_op_t;

endpackage

FILE: rtl/spq_cell.sv
module spq_cell
	import spq_pkg::*;
#(
	parameter int IDX   = 0,
	parameter int PB    = 4,
	parameter int PLB   = 32,
	parameter int CNT_W = 5
) (
	input  logic             clk,
	input  spq_op_t          op,
	input  logic [CNT_W-1:0] count,
	input  logic [PB-1:0]    new_prio,
	input  logic [PLB-1:0]   new_payload,
	input  logic             left_keep,
	input  logic [PB-1:0]    left_prio,
	input  logic [PLB-1:0]   left_payload,
	input  logic [PB-1:0]    right_prio,
	input  logic [PLB-1:0]   right_payload,
	output logic             keep,
	output logic [PB-1:0]    prio_q,
	output logic [PLB-1:0]   payload_q
);

	// entry stays put on a push when it is held and ranks at or above the new one
	assign keep = (CNT_W'(IDX) < count) && (prio_q >= new_prio);

	always_ff @(posedge clk) begin
		if (op.push && !keep) begin
			if (left_keep) begin
				prio_q    <= new_prio;
				payload_q <= new_payload;
			end else begin
				prio_q    <= left_prio;
				payload_q <= left_payload;
			end
		end else if (op.pop) begin
			prio_q    <= right_prio;
			payload_q <= right_payload;
		end
	end

endmodule

FILE: rtl/spq_outbuf.sv
module spq_outbuf
	import spq_pkg::*;
#(
	parameter int DATA_W = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [DATA_W-1:0]   in_data,
	input  logic [STATUS_W-1:0] in_user,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [DATA_W-1:0]   out_data,
	output logic [STATUS_W-1:0] out_user
);

	logic                out_v_q;
	logic [DATA_W-1:0]   out_data_q;
	logic [STATUS_W-1:0] out_user_q;
	logic                skid_v_q;
	logic [DATA_W-1:0]   skid_data_q;
	logic [STATUS_W-1:0] skid_user_q;
	logic                take;
	logic                put;

	assign in_ready  = !skid_v_q;
	assign put       = in_valid && in_ready;
	assign take      = out_v_q && out_ready;
	assign out_valid = out_v_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (take || !out_v_q) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= put;
			end
		end else if (put) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take || !out_v_q) begin
			if (skid_v_q) begin
				out_data_q <= skid_data_q;
				out_user_q <= skid_user_q;
			end else if (put) begin
				out_data_q <= in_data;
				out_user_q <= in_user;
			end
		end else if (put) begin
			skid_data_q <= in_data;
			skid_user_q <= in_user;
		end
	end

endmodule

FILE: rtl/stable_priority_queue_core.sv
// Bounded priority queue kept sorted in a row of QUEUE_DEPTH cells, head in
// cell 0. Every word on s_ is a push (tuser 0) or a pop (tuser 1), and each
// yields one result word on m_ with status, popped entry and the occupancy
// after the operation. On a push every cell compares its own priority with the
// new one in parallel and either holds, loads the new entry or takes its left
// neighbor's; a pop shifts every cell one place left. One word is taken per
// clock while s_tready is high. Results pass through a two-word output buffer,
// so input keeps flowing while m_tready is low until that buffer is full.
// cfg_ready is always high; capacity resets to 16 and is clipped to the depth.
module stable_priority_queue_core
	import spq_pkg::*;
#(
	parameter int QUEUE_DEPTH   = 16,
	parameter int PRIORITY_BITS = 4,
	parameter int PAYLOAD_BITS  = 32,
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
	localparam int IN_W  = ((PRIORITY_BITS + PAYLOAD_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((PRIORITY_BITS + PAYLOAD_BITS + CNT_W + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CAP_W-1:0]    cfg_data,   // capacity
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [IN_W-1:0]     s_tdata,    // priority_req, msg_payload
	input  logic                s_tuser,    // mode
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_W-1:0]    m_tdata,    // out_priority, out_payload, occupancy
	output logic [STATUS_W-1:0] m_tuser     // status
);

	localparam int PB    = PRIORITY_BITS;
	localparam int PLB   = PAYLOAD_BITS;
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic [PB-1:0]    new_prio;
	logic [PLB-1:0]   new_payload;
	logic             accept;
	logic             full;
	logic             empty;
	spq_op_t          op;
	status_t          status;
	logic [PB-1:0]    res_prio;
	logic [PLB-1:0]   res_payload;
	logic [OUT_W-1:0] res_data;

	logic [PB-1:0]  prio_w    [QUEUE_DEPTH];
	logic [PLB-1:0] payload_w [QUEUE_DEPTH];
	logic           keep_w    [QUEUE_DEPTH];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	assign new_prio    = s_tdata[PB-1:0];
	assign new_payload = s_tdata[PB+PLB-1:PB];
	assign accept      = s_tvalid && s_tready;

	assign full  = (CMP_W'(count_q) >= CMP_W'(capacity_q)) ||
		(count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		op.push     = 1'b0;
		op.pop      = 1'b0;
		status      = ST_OK;
		count_next  = count_q;
		res_prio    = '0;
		res_payload = '0;
		if (s_tuser == MODE_PUSH) begin
			if (full) begin
				status = ST_FULL;
			end else begin
				op.push    = accept;
				count_next = count_q + 1'b1;
			end
		end else begin
			if (empty) begin
				status = ST_EMPTY;
			end else begin
				op.pop      = accept;
				count_next  = count_q - 1'b1;
				res_prio    = prio_w[0];
				res_payload = payload_w[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_next;
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic           left_keep;
		logic [PB-1:0]  left_prio;
		logic [PLB-1:0] left_payload;
		logic [PB-1:0]  right_prio;
		logic [PLB-1:0] right_payload;

		if (i == 0) begin : g_head
			assign left_keep    = 1'b1;
			assign left_prio    = new_prio;
			assign left_payload = new_payload;
		end else begin : g_body
			assign left_keep    = keep_w[i-1];
			assign left_prio    = prio_w[i-1];
			assign left_payload = payload_w[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_prio    = prio_w[i];
			assign right_payload = payload_w[i];
		end else begin : g_mid
			assign right_prio    = prio_w[i+1];
			assign right_payload = payload_w[i+1];
		end

		spq_cell #(
			.IDX   (i),
			.PB    (PB),
			.PLB   (PLB),
			.CNT_W (CNT_W)
		) u_cell (
			.clk           (clk),
			.op            (op),
			.count         (count_q),
			.new_prio      (new_prio),
			.new_payload   (new_payload),
			.left_keep     (left_keep),
			.left_prio     (left_prio),
			.left_payload  (left_payload),
			.right_prio    (right_prio),
			.right_payload (right_payload),
			.keep          (keep_w[i]),
			.prio_q        (prio_w[i]),
			.payload_q     (payload_w[i])
		);
	end

	assign res_data = OUT_W'({count_next, res_payload, res_prio});

	spq_outbuf #(
		.DATA_W (OUT_W)
	) u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (res_data),
		.in_user   (status),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser)
	);

endmodule

FILE: rtl/spq_checker.sv
`include "stable_priority_queue_core_macros.svh"

module spq_checker
	import spq_pkg::*;
#(
	parameter int QUEUE_DEPTH   = 16,
	parameter int PRIORITY_BITS = 4,
	parameter int PAYLOAD_BITS  = 32,
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
	localparam int OUT_W = ((PRIORITY_BITS + PAYLOAD_BITS + CNT_W + 7) / 8) * 8
) (
	input logic                clk,
	input logic                arst_n,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [OUT_W-1:0]    m_tdata,
	input logic [STATUS_W-1:0] m_tuser
);

	localparam int ENT_W = PRIORITY_BITS + PAYLOAD_BITS;

	logic [CNT_W-1:0] occ;
	logic [ENT_W-1:0] entry;

	assign occ   = m_tdata[ENT_W+CNT_W-1:ENT_W];
	assign entry = m_tdata[ENT_W-1:0];

	`SPQ_ASSERT_NOW(a_fail_no_entry, clk, arst_n, m_tvalid && (m_tuser != ST_OK), entry == '0)
	`SPQ_ASSERT_NOW(a_empty_occ_zero, clk, arst_n, m_tvalid && (m_tuser == ST_EMPTY), occ == '0)
	`SPQ_ASSERT_NOW(a_occ_bound, clk, arst_n, m_tvalid, occ <= CNT_W'(QUEUE_DEPTH))
	`SPQ_ASSERT_NEXT(a_stall_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind stable_priority_queue_core spq_checker #(
	.QUEUE_DEPTH   (QUEUE_DEPTH),
	.PRIORITY_BITS (PRIORITY_BITS),
	.PAYLOAD_BITS  (PAYLOAD_BITS)
) u_spq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

FILE: tb/stable_priority_queue_core_test.sv
`timescale 1ns / 100ps

module stable_priority_queue_core_test;
	import spq_pkg::*;

	localparam int DEPTH = 16;
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		mode_t       mode;
		logic [3:0]  pri;
		logic [31:0] pay;
	} request_t;

	typedef struct {
		status_t     status;
		logic [3:0]  pri;
		logic [31:0] pay;
		logic [4:0]  occ;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CAP_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [39:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [STATUS_W-1:0] m_tuser;

	stable_priority_queue_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// shadow of the sorted entry row
	logic [3:0]  sorted_pri [DEPTH];
	logic [31:0] sorted_pay [DEPTH];
	int          held = 0;
	logic [4:0]  capacity_reg = CAP_RESET;

	request_t pending_words [$];
	outcome_t results_due [$];
	request_t next_word;
	outcome_t want;
	outcome_t got;
	bit in_taken = 0;
	int idle_pct = 32;
	int err_count = 0;
	int stall_cycles = 0;
	int n_push_ok = 0;
	int n_full = 0;
	int n_pop_ok = 0;
	int n_empty = 0;

	function automatic outcome_t apply_op(request_t rq);
		outcome_t r;
		int lim;
		int pos;
		r.status = ST_OK;
		r.pri = '0;
		r.pay = '0;
		lim = (capacity_reg < DEPTH) ? int'(capacity_reg) : DEPTH;
		if (rq.mode == MODE_PUSH) begin
			if (held >= lim) begin
				r.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < held && sorted_pri[pos] >= rq.pri)
					pos++;
				for (int i = held; i > pos; i--) begin
					sorted_pri[i] = sorted_pri[i-1];
					sorted_pay[i] = sorted_pay[i-1];
				end
				sorted_pri[pos] = rq.pri;
				sorted_pay[pos] = rq.pay;
				held++;
			end
		end else begin
			if (held == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.pri = sorted_pri[0];
				r.pay = sorted_pay[0];
				for (int i = 1; i < held; i++) begin
					sorted_pri[i-1] = sorted_pri[i];
					sorted_pay[i-1] = sorted_pay[i];
				end
				held--;
			end
		end
		r.occ = 5'(held);
		return r;
	endfunction

	initial begin
		forever #6 clk = ~clk;
	end

	// driver
	always @(negedge clk) begin
		if (!s_tvalid || in_taken) begin
			if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
				next_word = pending_words.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= next_word.mode;
				s_tdata <= {4'b0, next_word.pay, next_word.pri};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= arst_n && ($urandom_range(99) >= idle_pct);
	end

	// monitor
	always @(posedge clk) begin
		in_taken = s_tvalid && s_tready;
		if (cfg_valid && cfg_ready)
			capacity_reg = cfg_data;
		if (in_taken) begin
			next_word.mode = mode_t'(s_tuser);
			next_word.pri = s_tdata[3:0];
			next_word.pay = s_tdata[35:4];
			want = apply_op(next_word);
			case (want.status)
				ST_OK: begin
					if (next_word.mode == MODE_PUSH)
						n_push_ok++;
					else
						n_pop_ok++;
				end
				ST_FULL: n_full++;
				default: n_empty++;
			endcase
			results_due.push_back(want);
		end
		if (m_tvalid && m_tready) begin
			got.status = status_t'(m_tuser);
			got.pri = m_tdata[3:0];
			got.pay = m_tdata[35:4];
			got.occ = m_tdata[40:36];
			if (results_due.size() == 0) begin
				$display("%0t: unexpected word status %0d pri %0d pay %h occ %0d", $time,
					got.status, got.pri, got.pay, got.occ);
				err_count++;
			end else begin
				want = results_due.pop_front();
				if (got.status !== want.status || got.pri !== want.pri ||
						got.pay !== want.pay || got.occ !== want.occ) begin
					$display("%0t: mismatch expected status %0d pri %0d pay %h occ %0d",
						$time, want.status, want.pri, want.pay, want.occ);
					$display("%0t:          actual   status %0d pri %0d pay %h occ %0d",
						$time, got.status, got.pri, got.pay, got.occ);
					err_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic add_word(input mode_t mode, input logic [3:0] pri, input logic [31:0] pay);
		request_t rq;
		rq.mode = mode;
		rq.pri = pri;
		rq.pay = pay;
		pending_words.push_back(rq);
	endtask

	task automatic drain();
		while (pending_words.size() != 0 || s_tvalid || results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic add_random(input int count, input int push_pct);
		logic [3:0] pri;
		logic [31:0] pay;
		for (int k = 0; k < count; k++) begin
			// a coarse priority set makes ties common
			if ($urandom_range(1))
				pri = 4'($urandom_range(15));
			else
				pri = 4'($urandom_range(3)) * 4'd5;
			case ($urandom_range(15))
				0: pay = '0;
				1: pay = '1;
				default: pay = $urandom;
			endcase
			add_word(($urandom_range(99) < push_pct) ? MODE_PUSH : MODE_POP, pri, pay);
		end
	endtask

	logic [CAP_W-1:0] phase_caps [10] = '{5'd31, 5'd1, 5'd5, 5'd16, 5'd0,
		5'd17, 5'd9, 5'd3, 5'd16, 5'd12};

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// ties keep arrival order
		write_capacity(5'd16);
		add_word(MODE_PUSH, 4'd0, 32'h0000_0000);
		add_word(MODE_PUSH, 4'd15, 32'hffff_ffff);
		add_word(MODE_PUSH, 4'd15, 32'h5a5a_5a5a);
		add_word(MODE_PUSH, 4'd7, 32'h1234_5678);
		add_word(MODE_PUSH, 4'd0, 32'ha5a5_a5a5);
		repeat (5) add_word(MODE_POP, 4'd0, 32'h0);
		drain();

		// full and empty
		write_capacity(5'd2);
		add_word(MODE_PUSH, 4'd3, 32'h1);
		add_word(MODE_PUSH, 4'd3, 32'h2);
		add_word(MODE_PUSH, 4'd9, 32'h3);
		add_word(MODE_POP, 4'd0, 32'h0);
		add_word(MODE_POP, 4'd0, 32'h0);
		drain();
		write_capacity(5'd0);
		add_word(MODE_PUSH, 4'd15, 32'hffff_ffff);
		add_word(MODE_POP, 4'd15, 32'hffff_ffff);
		drain();

		// capacity dropped below the occupancy
		write_capacity(5'd16);
		add_word(MODE_PUSH, 4'd1, 32'h10);
		add_word(MODE_PUSH, 4'd2, 32'h20);
		add_word(MODE_PUSH, 4'd1, 32'h30);
		drain();
		write_capacity(5'd2);
		add_word(MODE_PUSH, 4'd4, 32'h40);
		add_word(MODE_POP, 4'd0, 32'h0);
		add_word(MODE_POP, 4'd0, 32'h0);
		add_word(MODE_PUSH, 4'd4, 32'h50);
		add_word(MODE_POP, 4'd0, 32'h0);
		add_word(MODE_POP, 4'd0, 32'h0);
		drain();

		for (int p = 0; p < 10; p++) begin
			write_capacity(phase_caps[p]);
			idle_pct = (p == 3) ? 0 : 32;
			add_random(140, (p % 2 == 0) ? 65 : 38);
			drain();
		end
		idle_pct = 32;
		repeat (8) @(posedge clk);

		$display("covered %0d pushes, %0d full rejects, %0d pops, %0d empty pops",
			n_push_ok, n_full, n_pop_ok, n_empty);
		$display("over capacities 0 to 31 with random stalls on both streams");
		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
